// File: hw/rtl/sliding_window_regression_predictor_defines.svh
// Assertion macros for the regression predictor.
// Each macro takes a label, clock, reset, antecedent, consequent and message.
`ifndef SLIDING_WINDOW_REGRESSION_PREDICTOR_DEFINES_SVH
`define SLIDING_WINDOW_REGRESSION_PREDICTOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define SWRP_ASSERT_ALWAYS(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define SWRP_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SWRP_ASSERT_ALWAYS(name, clk, rst, ante, cons, msg)
`define SWRP_ASSERT_NEXT(name, clk, rst, ante, cons, msg)
`endif

`endif

// File: hw/rtl/swrp_pkg.sv
`timescale 1ns / 1ps
package swrp_pkg;

  localparam int SAMPLE_W = 32;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic clear;
    logic step;
  } mac_ctl_t;

  // Status of the divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: hw/rtl/swrp_if.sv
`timescale 1ns / 1ps
interface swrp_sample_if import swrp_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface swrp_result_if import swrp_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t prediction;
  logic    from_fit;

  modport source (output valid, output prediction, output from_fit, input ready);
  modport sink (input valid, input prediction, input from_fit, output ready);
endinterface

// File: hw/rtl/swrp_cell.sv
`timescale 1ns / 1ps
module swrp_cell import swrp_pkg::*; (
  input  logic    clk,
  input  logic    shift,
  input  sample_t din,
  output sample_t dout
);

  sample_t value;

  // Take the neighbor's sample on every shift, hold otherwise.
  always_ff @(posedge clk) begin
    if (shift) begin
      value <= din;
    end
  end

  assign dout = value;

endmodule

// File: hw/rtl/swrp_mac.sv
`timescale 1ns / 1ps
module swrp_mac import swrp_pkg::*; #(
  parameter int WINDOW = 8,
  parameter int ACC_W  = 40
) (
  input  logic                    clk,
  input  logic                    rst,
  input  mac_ctl_t                ctl,
  input  sample_t                 operand,
  output logic signed [ACC_W-1:0] acc
);

  localparam int WT_W   = $clog2(2 * WINDOW - 1) + 1;
  localparam int PROD_W = SAMPLE_W + WT_W;
  localparam logic signed [WT_W-1:0] WT_FIRST = WT_W'(1 - WINDOW);
  localparam logic signed [WT_W-1:0] WT_STEP  = WT_W'(3);

  logic signed [WT_W-1:0]   weight;
  logic signed [PROD_W-1:0] prod;
  logic                     prod_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctl.step;
    end
  end

  // Weight runs from 1-WINDOW upward in steps of three, oldest sample first.
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      weight <= WT_FIRST;
    end else if (ctl.step) begin
      weight <= weight + WT_STEP;
    end
    if (ctl.step) begin
      prod <= PROD_W'(operand) * PROD_W'(weight);
    end
    if (ctl.clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + ACC_W'(prod);
    end
  end

endmodule

// File: hw/rtl/swrp_div.sv
`timescale 1ns / 1ps
module swrp_div import swrp_pkg::*; #(
  parameter int NUM_W   = 40,
  parameter int DIVISOR = 28
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  output logic [NUM_W-1:0] quo,
  output div_stat_t        stat
);

  // Long division by a constant, one DIG_W-bit quotient digit at a time,
  // most significant first. For each digit, the digit first comes from a
  // multiply by the rounded-up reciprocal, then the remainder for the next
  // digit is formed.
  localparam int DIG_W  = 16;
  localparam int NDIG   = (NUM_W + DIG_W - 1) / DIG_W;
  localparam int SH_W   = NDIG * DIG_W;
  localparam int REM_W  = $clog2(DIVISOR + 1);
  localparam int X_W    = REM_W + DIG_W;
  localparam int RCP_W  = X_W + 2;
  localparam int PROD_W = X_W + RCP_W;
  localparam int SHIFT  = X_W + REM_W;
  localparam int CNT_W  = $clog2(NDIG + 1);
  localparam logic [63:0] RCP_FULL =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [RCP_W-1:0] RCP   = RCP_W'(RCP_FULL);
  localparam logic [X_W-1:0]   DIV_X = X_W'(DIVISOR);

  logic [SH_W-1:0]   shreg;
  logic [SH_W-1:0]   quo_reg;
  logic [REM_W-1:0]  rem;
  logic [X_W-1:0]    x_reg;
  logic [DIG_W-1:0]  qdig;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              phase;
  logic              done;
  logic [X_W-1:0]    x;
  logic [PROD_W-1:0] prod;
  logic [X_W-1:0]    qd;

  // Partial numerator: remainder so far with the next digit below it.
  assign x    = {rem, shreg[SH_W-1 -: DIG_W]};
  assign prod = PROD_W'(x) * PROD_W'(RCP);
  assign qd   = X_W'(qdig) * DIV_X;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 1'b0;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        phase <= 1'b0;
        cnt   <= CNT_W'(NDIG);
      end else if (busy) begin
        phase <= !phase;
        if (phase) begin
          cnt <= cnt - 1'b1;
          if (cnt == CNT_W'(1)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg   <= SH_W'(num);
      rem     <= '0;
      quo_reg <= '0;
    end else if (busy && !phase) begin
      qdig  <= prod[SHIFT +: DIG_W];
      x_reg <= x;
      shreg <= {shreg[SH_W-DIG_W-1:0], {DIG_W{1'b0}}};
    end else if (busy && phase) begin
      rem     <= REM_W'(x_reg - qd);
      quo_reg <= {quo_reg[SH_W-DIG_W-1:0], qdig};
    end
  end

  assign quo  = quo_reg[NUM_W-1:0];
  assign stat = '{busy: busy, done: done};

endmodule

// File: hw/rtl/sliding_window_regression_predictor.sv
`timescale 1ns / 1ps
// Sliding-window linear-regression predictor. Each transfer on the samples
// channel carries one signed Q16.16 value; each transfer on the results
// channel returns one prediction of the next value, rounded to nearest (ties
// away from zero) and saturated to 32 bits, with from_fit set when it came
// from the least-squares line over the last WINDOW samples. During warm-up
// (fewer than WINDOW-1 earlier samples) the sample itself comes back with
// from_fit clear. Items are handled one at a time. The accumulator width
// is ACC_W = 33 + clog2(2*WINDOW^2). For a fitted item the history chain
// rotates once past the single multiply-accumulate unit, then the constant
// divider settles one 16-bit quotient digit at a time (a multiply by the
// reciprocal of the denominator, then the remainder for the next digit).
// A finished result waits in the output register, so the next sample is
// taken while it sits there.
`include "sliding_window_regression_predictor_defines.svh"
module sliding_window_regression_predictor import swrp_pkg::*; #(
  parameter int WINDOW = 8
) (
  input  logic          clk,
  input  logic          rst,
  swrp_sample_if.sink   samples,
  swrp_result_if.source results
);

  // History depth and derived widths.
  localparam int HIST   = WINDOW - 1;
  localparam int CNT_W  = $clog2(WINDOW);
  localparam int DENOM  = WINDOW * (WINDOW - 1) / 2;
  localparam int HALF   = DENOM / 2;
  localparam int ACC_W  = SAMPLE_W + 1 + $clog2(2 * WINDOW * WINDOW);
  localparam int HI_W   = ACC_W - SAMPLE_W + 1;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ACC  = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_RND  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]             state;
  logic [CNT_W-1:0]       items_seen;
  logic [CNT_W-1:0]       step;
  sample_t                cur;
  sample_t                res_pred;
  logic                   res_fit;
  logic                   acc_neg;
  logic                   out_valid;
  sample_t                prediction;
  logic                   from_fit;

  logic                   in_xfer;
  logic                   full;
  logic                   chain_shift;
  sample_t                feed;
  sample_t                hist [HIST];
  mac_ctl_t               mac_ctl;
  logic signed [ACC_W-1:0] acc;
  logic [ACC_W-1:0]       acc_mag;
  logic [ACC_W-1:0]       num;
  logic [ACC_W-1:0]       quo;
  div_stat_t              div_stat;
  logic [HI_W-1:0]        quo_hi;
  logic                   pos_sat;
  logic                   neg_sat;
  sample_t                fit_value;

  assign samples.ready = (state == S_IDLE);
  assign in_xfer       = samples.valid && samples.ready;
  assign full          = (items_seen == CNT_W'(HIST));

  // History chain. In warm-up the new sample shifts straight in. For a fit
  // the chain shifts on every step: the first step drops the oldest sample
  // and takes the current one, the rest rotate the head back to the tail,
  // so each sample passes the multiplier once, oldest first, and the chain
  // ends in order with the current sample at the tail.
  assign chain_shift = (in_xfer && !full) || (state == S_ACC);

  always_comb begin
    if (state == S_ACC) begin
      feed = (step == '0) ? cur : hist[0];
    end else begin
      feed = samples.sample;
    end
  end

  for (genvar g = 0; g < HIST; g++) begin : g_chain
    if (g == HIST - 1) begin : g_tail
      swrp_cell u_cell (
        .clk   (clk),
        .shift (chain_shift),
        .din   (feed),
        .dout  (hist[g])
      );
    end else begin : g_body
      swrp_cell u_cell (
        .clk   (clk),
        .shift (chain_shift),
        .din   (hist[g+1]),
        .dout  (hist[g])
      );
    end
  end

  // Weighted sum of the window through one multiply-accumulate unit.
  assign mac_ctl = '{clear: in_xfer, step: (state == S_ACC)};

  swrp_mac #(
    .WINDOW (WINDOW),
    .ACC_W  (ACC_W)
  ) u_mac (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mac_ctl),
    .operand (hist[0]),
    .acc     (acc)
  );

  // Divide the magnitude plus half the denominator; sign goes back after.
  assign acc_mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
  assign num     = acc_mag + ACC_W'(HALF);

  swrp_div #(
    .NUM_W   (ACC_W),
    .DIVISOR (DENOM)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_RND),
    .num   (num),
    .quo   (quo),
    .stat  (div_stat)
  );

  // Saturate: positive above 2^31-1, negative beyond 2^31.
  assign quo_hi  = quo[ACC_W-1:SAMPLE_W-1];
  assign pos_sat = |quo_hi;
  assign neg_sat = (quo_hi > HI_W'(1)) ||
                   ((quo_hi == HI_W'(1)) && (|quo[SAMPLE_W-2:0]));

  always_comb begin
    if (acc_neg) begin
      fit_value = neg_sat ? SAMPLE_MIN
                          : sample_t'(SAMPLE_W'(0) - quo[SAMPLE_W-1:0]);
    end else begin
      fit_value = pos_sat ? SAMPLE_MAX : sample_t'(quo[SAMPLE_W-1:0]);
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      items_seen <= '0;
      out_valid  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            state <= full ? S_ACC : S_FIN;
          end
        end
        S_ACC: begin
          if (step == CNT_W'(WINDOW - 1)) begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          state <= S_RND;
        end
        S_RND: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || results.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // Count earlier items, stop at a full history.
      if (in_xfer && !full) begin
        items_seen <= items_seen + 1'b1;
      end

      // Hold the output until taken; reload straight away from the finish.
      if (state == S_FIN) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cur  <= samples.sample;
      step <= '0;
    end else if (state == S_ACC) begin
      step <= step + 1'b1;
    end
    if (in_xfer && !full) begin
      res_pred <= samples.sample;
      res_fit  <= 1'b0;
    end else if ((state == S_DIV) && div_stat.done) begin
      res_pred <= fit_value;
      res_fit  <= 1'b1;
    end
    if (state == S_RND) begin
      acc_neg <= acc[ACC_W-1];
    end
    if ((state == S_FIN) && (!out_valid || results.ready)) begin
      prediction <= res_pred;
      from_fit   <= res_fit;
    end
  end

  assign results.valid      = out_valid;
  assign results.prediction = prediction;
  assign results.from_fit   = from_fit;

  // Checks.
  `SWRP_ASSERT_ALWAYS(a_ready_not_dividing, clk, rst, samples.ready, !div_stat.busy, "sample taken while dividing")
  `SWRP_ASSERT_NEXT(a_full_starts_fit, clk, rst, in_xfer && full, state == S_ACC, "full history did not start a fit")
  `SWRP_ASSERT_ALWAYS(a_count_capped, clk, rst, 1'b1, items_seen <= CNT_W'(HIST), "item count past history depth")
  `SWRP_ASSERT_ALWAYS(a_fit_needs_history, clk, rst, results.valid && results.from_fit, full, "fitted result before history filled")

endmodule
